// ----- src/ray_march_volume_integrator_unit_macros.svh -----
// Assertion macros used by the ray march integrator tracer module.
`ifndef RAY_MARCH_VOLUME_INTEGRATOR_UNIT_MACROS_SVH
`define RAY_MARCH_VOLUME_INTEGRATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk outside reset.
`define RMVI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmvi assertion failed");

// Next-cycle implication, checked on clk outside reset.
`define RMVI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmvi assertion failed");

`endif

// ----- src/rmvi_pkg.sv -----
// Types, constants and state codes of the ray march volume integrator.
`default_nettype none
package rmvi_pkg;

  localparam int VOL_DIM     = 64;
  localparam int MAX_STEPS   = 4096;
  localparam int COORD_W     = $clog2(VOL_DIM);
  localparam int ADDR_W      = 3 * COORD_W;
  localparam int STORE_DEPTH = VOL_DIM * VOL_DIM * VOL_DIM;
  localparam int FRAC        = 14;
  localparam int POS_W       = 32;
  localparam int SIZE_W      = 7;
  localparam int BASE_W      = SIZE_W + 1;
  localparam int VAL_W       = 16;
  localparam int IDX_W       = 18;
  localparam int STEPI_W     = 12;
  localparam int DSTEP_W     = 18;
  localparam int ORG_W       = 24;
  localparam int SUM_W       = 48;
  localparam int CNT_W       = 13;
  localparam int SAMP_W      = 20;
  localparam int ACC_W       = 61;
  localparam int CFG_IDX_W   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 8'd3;

  typedef struct packed {
    logic              interp;
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_z;
  } cfg_t;

  typedef struct packed {
    logic        [STEPI_W-1:0] first_step;
    logic        [STEPI_W-1:0] last_step;
    logic signed [DSTEP_W-1:0] step_x;
    logic signed [DSTEP_W-1:0] step_y;
    logic signed [DSTEP_W-1:0] step_z;
    logic signed [ORG_W-1:0]   origin_x;
    logic signed [ORG_W-1:0]   origin_y;
    logic signed [ORG_W-1:0]   origin_z;
  } trace_req_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  wdata;
  } ram_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] ray_sum;
    logic [CNT_W-1:0] samples_taken;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_POS, S_STEP, S_NRD, S_CRD, S_CVZ, S_CACC, S_ROUND, S_ACC, S_DONE
  } trc_state_t;

endpackage
`default_nettype wire

// ----- src/ray_march_volume_integrator_unit.sv -----
// Top level of the ray march volume integrator: stream ports, registers, memory.
//
// A voxel write beat (in_tuser = 0) to an index in range is stored; it returns nothing.
// A trace beat (in_tuser = 1) passes the setup states S_MUL and S_POS. A step runs
// S_STEP and S_ACC; when the position lies inside the sampled range, S_NRD comes
// between them in nearest mode, or in trilinear mode eight passes of S_CRD, S_CVZ and
// S_CACC (one per corner, as the voxel memory is single-port) and then S_ROUND.
// S_DONE hands over the result once res_ready is high. The result waits in an output
// register, so the next beat is taken while it is still pending. The voxel memory is
// not cleared, so voxels must be written before they are read.
`default_nettype none
module ray_march_volume_integrator_unit import rmvi_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // voxel_index, voxel_value, first_step, last_step, step_x, step_y, step_z,
  // origin_x, origin_y, origin_z
  input  wire logic [183:0] in_tdata,
  // req_type
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // ray_sum, samples_taken, zero fill
  output logic      [63:0]  out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SIZE_W-1:0]    cfg_data
);

  cfg_t       cfg_r;
  trace_req_t treq;
  ram_req_t   trc_ram, ram_req;
  result_t    res, out_r;
  logic       out_valid_r, trc_idle, trc_done, res_ready, in_fire, wr;
  logic [VAL_W-1:0] rdata;
  logic [IDX_W-1:0] vidx;

  assign in_tready = trc_idle;
  assign in_fire   = in_tvalid && in_tready;
  assign vidx      = in_tdata[17:0];
  assign wr        = in_fire && !in_tuser && ({1'b0, vidx} < (IDX_W+1)'(STORE_DEPTH));
  assign cfg_ready = 1'b1;

  assign treq.first_step = in_tdata[45:34];
  assign treq.last_step  = in_tdata[57:46];
  assign treq.step_x     = in_tdata[75:58];
  assign treq.step_y     = in_tdata[93:76];
  assign treq.step_z     = in_tdata[111:94];
  assign treq.origin_x   = in_tdata[135:112];
  assign treq.origin_y   = in_tdata[159:136];
  assign treq.origin_z   = in_tdata[183:160];

  always_comb begin
    if (wr) begin
      ram_req.we    = 1'b1;
      ram_req.re    = 1'b0;
      ram_req.addr  = vidx[ADDR_W-1:0];
      ram_req.wdata = in_tdata[33:18];
    end else begin
      ram_req = trc_ram;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{interp: 1'b1, size_x: SIZE_W'(64), size_y: SIZE_W'(64), size_z: SIZE_W'(64)};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE:   cfg_r.interp <= cfg_data[0];
        CFG_SIZE_X: cfg_r.size_x <= cfg_data;
        CFG_SIZE_Y: cfg_r.size_y <= cfg_data;
        CFG_SIZE_Z: cfg_r.size_z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= trc_done;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && trc_done) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.samples_taken, out_r.ray_sum};

  rmvi_voxel_ram #(.ADDR_W(ADDR_W), .DATA_W(VAL_W)) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .re    (ram_req.re),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (rdata)
  );

  rmvi_tracer u_tracer (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_fire && in_tuser),
    .req       (treq),
    .cfg       (cfg_r),
    .idle      (trc_idle),
    .ram_req   (trc_ram),
    .ram_rdata (rdata),
    .done      (trc_done),
    .result    (res),
    .res_ready (res_ready)
  );

endmodule
`default_nettype wire

// ----- src/rmvi_voxel_ram.sv -----
// Single-port synchronous voxel memory with registered read data.
`default_nettype none
module rmvi_voxel_ram #(
  parameter int ADDR_W = 18,
  parameter int DATA_W = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [0:(1<<ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// ----- src/rmvi_tracer.sv -----
// Ray walker: steps positions, samples the voxel memory and sums the samples.
`default_nettype none
`include "ray_march_volume_integrator_unit_macros.svh"
module rmvi_tracer import rmvi_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire trace_req_t req,
  input  wire cfg_t       cfg,
  output logic            idle,
  output ram_req_t        ram_req,
  input  wire logic [VAL_W-1:0] ram_rdata,
  output logic            done,
  output result_t         result,
  input  wire logic       res_ready
);

  localparam logic signed [POS_W-1:0] HALF = POS_W'(1 << (FRAC - 1));
  localparam logic [FRAC:0] ONE = (FRAC+1)'(1 << FRAC);

  trc_state_t state_r, state_nxt;

  trace_req_t                req_r;
  logic                      mode_r;
  logic        [SIZE_W-1:0]  n_r     [3];
  logic signed [POS_W-1:0]   p_r     [3];
  logic signed [STEPI_W+DSTEP_W:0] mul_r [3];
  logic signed [BASE_W-1:0]  base_r  [3];
  logic        [FRAC-1:0]    w1_r    [3];
  logic        [CNT_W-1:0]   count_r, k_r;
  logic        [2:0]         c_r;
  logic        [2*FRAC+1:0]  wxy_r;
  logic        [FRAC:0]      wz_r;
  logic                      inr_r;
  logic        [VAL_W+FRAC:0] vz_r;
  logic        [ACC_W-1:0]   acc_r;
  logic        [SAMP_W-1:0]  sample_r;
  logic        [SUM_W-1:0]   sum_r;

  logic                      in_tri  [3];
  logic                      in_nst  [3];
  logic signed [POS_W-1:0]   q_c     [3];
  logic        [SIZE_W-1:0]  nidx_c  [3];
  logic signed [BASE_W-1:0]  cc      [3];
  logic                      cok     [3];
  logic        [FRAC:0]      wsel    [3];
  logic signed [DSTEP_W-1:0] stp     [3];
  logic signed [ORG_W-1:0]   org     [3];
  logic                      tri_ok, nst_ok, corner_ok;
  logic        [CNT_W-1:0]   cnt_c;
  logic        [SUM_W:0]     sum_add;

  assign stp = '{req_r.step_x, req_r.step_y, req_r.step_z};
  assign org = '{req_r.origin_x, req_r.origin_y, req_r.origin_z};

  // Per-axis range checks, trilinear base and weight, nearest index.
  always_comb begin
    logic signed [POS_W-1:0] lim;
    for (int a = 0; a < 3; a++) begin
      lim       = $signed(POS_W'({n_r[a], {FRAC{1'b0}}}));
      q_c[a]    = p_r[a] - HALF;
      in_tri[a] = !(p_r[a] < -HALF) && !(p_r[a] > lim + HALF);
      nidx_c[a] = p_r[a][FRAC+SIZE_W-1:FRAC];
      in_nst[a] = !p_r[a][POS_W-1] && !(p_r[a] > lim) && (nidx_c[a] < n_r[a]);
      cc[a]     = base_r[a] + $signed({{(BASE_W-1){1'b0}}, c_r[a]});
      cok[a]    = !cc[a][BASE_W-1] && (cc[a][SIZE_W-1:0] < n_r[a]);
      wsel[a]   = c_r[a] ? {1'b0, w1_r[a]} : (ONE - {1'b0, w1_r[a]});
    end
  end

  assign tri_ok    = in_tri[0] && in_tri[1] && in_tri[2];
  assign nst_ok    = in_nst[0] && in_nst[1] && in_nst[2];
  assign corner_ok = cok[0] && cok[1] && cok[2];
  assign sum_add   = {1'b0, sum_r} + (SUM_W+1)'(sample_r);

  always_comb begin
    if (req.first_step > req.last_step) begin
      cnt_c = '0;
    end else begin
      cnt_c = CNT_W'(req.last_step - req.first_step) + CNT_W'(1);
    end
    if (cnt_c > CNT_W'(MAX_STEPS)) begin
      cnt_c = CNT_W'(MAX_STEPS);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_POS;
      S_POS:   state_nxt = (count_r == '0) ? S_DONE : S_STEP;
      S_STEP: begin
        if (mode_r) begin
          state_nxt = tri_ok ? S_CRD : S_ACC;
        end else begin
          state_nxt = nst_ok ? S_NRD : S_ACC;
        end
      end
      S_NRD:   state_nxt = S_ACC;
      S_CRD:   state_nxt = S_CVZ;
      S_CVZ:   state_nxt = S_CACC;
      S_CACC:  state_nxt = (c_r == 3'd7) ? S_ROUND : S_CRD;
      S_ROUND: state_nxt = S_ACC;
      S_ACC:   state_nxt = (k_r + CNT_W'(1) == count_r) ? S_DONE : S_STEP;
      S_DONE:  if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs: memory reads and the finished result.
  always_comb begin
    ram_req = '0;
    idle    = 1'b0;
    done    = 1'b0;
    unique case (state_r)
      S_IDLE: idle = 1'b1;
      S_STEP: begin
        if (!mode_r && nst_ok) begin
          ram_req.re   = 1'b1;
          ram_req.addr = {nidx_c[2][COORD_W-1:0], nidx_c[1][COORD_W-1:0],
                          nidx_c[0][COORD_W-1:0]};
        end
      end
      S_CRD: begin
        ram_req.re   = corner_ok;
        ram_req.addr = {cc[2][COORD_W-1:0], cc[1][COORD_W-1:0], cc[0][COORD_W-1:0]};
      end
      S_DONE: done = 1'b1;
      default: ;
    endcase
  end

  assign result.ray_sum       = sum_r;
  assign result.samples_taken = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_r   <= req;
          mode_r  <= cfg.interp;
          n_r[0]  <= (cfg.size_x > SIZE_W'(VOL_DIM)) ? SIZE_W'(VOL_DIM) : cfg.size_x;
          n_r[1]  <= (cfg.size_y > SIZE_W'(VOL_DIM)) ? SIZE_W'(VOL_DIM) : cfg.size_y;
          n_r[2]  <= (cfg.size_z > SIZE_W'(VOL_DIM)) ? SIZE_W'(VOL_DIM) : cfg.size_z;
          count_r <= cnt_c;
        end
      end
      S_MUL: begin
        for (int a = 0; a < 3; a++) begin
          mul_r[a] <= $signed({1'b0, req_r.first_step}) * stp[a];
        end
      end
      S_POS: begin
        for (int a = 0; a < 3; a++) begin
          p_r[a] <= POS_W'(org[a]) + POS_W'(mul_r[a]);
        end
        k_r   <= '0;
        sum_r <= '0;
      end
      S_STEP: begin
        for (int a = 0; a < 3; a++) begin
          base_r[a] <= BASE_W'(q_c[a] >>> FRAC);
          w1_r[a]   <= q_c[a][FRAC-1:0];
        end
        c_r      <= '0;
        acc_r    <= '0;
        sample_r <= '0;
      end
      S_NRD: sample_r <= SAMP_W'(ram_rdata);
      S_CRD: begin
        wxy_r <= wsel[0] * wsel[1];
        wz_r  <= wsel[2];
        inr_r <= corner_ok;
      end
      S_CVZ: vz_r <= (inr_r ? ram_rdata : '0) * wz_r;
      S_CACC: begin
        acc_r <= acc_r + ACC_W'(vz_r * wxy_r);
        c_r   <= c_r + 3'd1;
      end
      S_ROUND: sample_r <= SAMP_W'((acc_r + (ACC_W'(1) << (3*FRAC - 1))) >> (3*FRAC));
      S_ACC: begin
        sum_r <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
        for (int a = 0; a < 3; a++) begin
          p_r[a] <= p_r[a] + POS_W'(stp[a]);
        end
        k_r <= k_r + CNT_W'(1);
      end
      default: ;
    endcase
  end

  `RMVI_ASSERT_NOW(a_no_read_idle, state_r == S_IDLE, !ram_req.re)
  `RMVI_ASSERT_NEXT(a_start_leaves_idle, state_r == S_IDLE && start, state_r == S_MUL)
  `RMVI_ASSERT_NOW(a_steps_bounded, state_r == S_STEP, k_r < count_r)
  `RMVI_ASSERT_NEXT(a_done_holds, state_r == S_DONE && !res_ready, state_r == S_DONE)

endmodule
`default_nettype wire
